[src/nrtbs_pkg.sv]
// Package for the NR transport block size pipeline: request, response and stage types,
// the standard TBS table, and small helper functions. No dependencies.
package nrtbs_pkg;

  localparam int unsigned TBS_TABLE_ENTRIES = 93;
  localparam int unsigned RE_CAP_PER_PRB    = 156;
  localparam int unsigned SMALL_LIMIT       = 3824;
  localparam int unsigned CB_LOW_RATE       = 3816;
  localparam int unsigned CB_HIGH_RATE      = 8424;
  localparam int unsigned TBS_MIN_BITS      = 24;
  localparam int unsigned LARGE_MIN         = 3840;
  localparam int unsigned LOW_RATE_X1024    = 256;
  localparam int unsigned TBS_MAX           = 4194303;
  localparam int unsigned SCALING_INVALID   = 3;

  // Reciprocal constants for the code-block count: floor(y / K) = (y * M) >> RECIP_SHIFT
  // holds exactly for y below 2^26.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam longint unsigned RECIP_LOW  =
      ((64'd1 << RECIP_SHIFT) + 64'(CB_LOW_RATE) - 64'd1) / 64'(CB_LOW_RATE);
  localparam longint unsigned RECIP_HIGH =
      ((64'd1 << RECIP_SHIFT) + 64'(CB_HIGH_RATE) - 64'd1) / 64'(CB_HIGH_RATE);

  // Pipeline layout: nine arithmetic stages, one restoring divider step per stage, one
  // final stage that forms the response.
  localparam int unsigned DIV_STEPS  = 26;
  localparam int unsigned DIV_FIRST  = 9;
  localparam int unsigned NUM_STAGES = DIV_FIRST + DIV_STEPS + 1;

  typedef struct packed {
    logic [3:0] symbol_count;
    logic [7:0] dmrs_res_per_prb;
    logic [8:0] prb_count;
    logic [1:0] tb_scaling;
    logic [9:0] code_rate_x1024;
    logic [3:0] qm_bits;
    logic [3:0] layer_count;
  } req_t;

  typedef struct packed {
    logic [21:0] tbs_bits;
    logic        bad_scaling;
  } rsp_t;

  typedef struct packed {
    logic        bad;
    logic [1:0]  scal;
    logic [9:0]  rate;
    logic [8:0]  prb;
    logic [7:0]  re;
    logic [7:0]  ql;
    logic [16:0] a;
    logic [17:0] b;
    logic [34:0] p;
    logic [34:0] q;
    logic [11:0] inum;
    logic        use_table;
    logic [4:0]  k;
    logic [11:0] sm;
    logic [25:0] np;
    logic [25:0] x;
    logic        one_cb;
    logic [54:0] prod;
    logic [13:0] c;
    logic [16:0] v;
    logic [25:0] xp;
    logic [16:0] rem;
    logic [21:0] tbs;
  } work_t;

  localparam logic [11:0] TBS_TABLE [TBS_TABLE_ENTRIES] = '{
    12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
    12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160, 12'd168,
    12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240, 12'd256, 12'd272, 12'd288,
    12'd304, 12'd320, 12'd336, 12'd352, 12'd368, 12'd384, 12'd408, 12'd432, 12'd456,
    12'd480, 12'd504, 12'd528, 12'd552, 12'd576, 12'd608, 12'd640, 12'd672, 12'd704,
    12'd736, 12'd768, 12'd808, 12'd848, 12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064,
    12'd1128, 12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352,
    12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864,
    12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472,
    12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104,
    12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
  };

  // Smallest table entry not below the quantized value.
  function automatic logic [11:0] tbs_lookup(input logic [11:0] val);
    logic [11:0] res;
    res = TBS_TABLE[TBS_TABLE_ENTRIES-1];
    for (int i = TBS_TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (TBS_TABLE[i] >= val) begin
        res = TBS_TABLE[i];
      end
    end
    return res;
  endfunction

  function automatic logic [5:0] msb_pos35(input logic [34:0] val);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 35; i++) begin
      if (val[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] msb_pos12(input logic [11:0] val);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 12; i++) begin
      if (val[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

[src/nr_transport_block_size_top.sv]
// Top level of the NR downlink transport block size calculator: a 36-stage pipeline.
// Depends on nrtbs_pkg for the request/response types, the TBS table and helpers.
//
//   Channel   Handshake                Payload
//   --------  -----------------------  ----------------------------------------
//   in        in_valid_i / in_ready_o  in_req_i  (nrtbs_pkg::req_t)
//   out       out_valid_o / out_ready_i out_rsp_o (nrtbs_pkg::rsp_t)
//   cfg       cfg_valid_i / cfg_ready_o cfg_data_i (overhead REs per PRB, 5 bits)
//
// One request can be accepted every cycle unless a stall on the output has filled every
// stage. The depth is set by the restoring divider (26 steps, one bit per stage) that
// rounds the size up to a multiple of eight times the code-block count.
// Reset clears the valid bits of all stages and the overhead register; there is no
// clearing pass. A stage holds its request while the stage after it is full and stalled,
// so a stall on the output fills bubbles first and drops in_ready_o only when every stage
// is occupied.
module nr_transport_block_size_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nrtbs_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nrtbs_pkg::rsp_t  out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [4:0]       cfg_data_i
);
  import nrtbs_pkg::*;

  logic [4:0]  ovh_q;
  work_t       st_q  [NUM_STAGES];
  work_t       st_d  [NUM_STAGES];
  logic        vld_q [NUM_STAGES];
  logic        adv   [NUM_STAGES];

  // The overhead is applied as a request enters the first stage, so a write only affects
  // requests accepted after it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ovh_q <= cfg_data_i;
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o = adv[0];

  // Stage arithmetic.
  always_comb begin
    logic [7:0]  gross;
    logic [8:0]  less;
    logic [7:0]  re_w;
    logic [3:0]  dsh;
    logic [34:0] lim;
    logic [5:0]  qmsb;
    logic [3:0]  imsb;
    logic [3:0]  ns;
    logic [11:0] qs;
    logic [4:0]  nl;
    logic [35:0] rsum;
    logic [35:0] npw;
    logic [25:0] npc;
    logic        low;
    logic [25:0] kc;
    logic [28:0] mc;
    logic [25:0] y;
    logic [17:0] rin;
    logic [25:0] tl;
    work_t       w;

    for (int s = 0; s < NUM_STAGES; s++) begin
      st_d[s] = (s == 0) ? st_q[0] : st_q[s-1];
    end

    // Stage 1: resource elements per PRB, Qm times layers, scaling check.
    w       = st_q[0];
    gross   = 8'(in_req_i.symbol_count) * 8'd12;
    less    = 9'(in_req_i.dmrs_res_per_prb) + 9'(ovh_q);
    re_w    = (9'(gross) > less) ? 8'(9'(gross) - less) : 8'd0;
    w.re    = (re_w > 8'(RE_CAP_PER_PRB)) ? 8'(RE_CAP_PER_PRB) : re_w;
    w.ql    = 8'(in_req_i.qm_bits) * 8'(in_req_i.layer_count);
    w.bad   = (in_req_i.tb_scaling == 2'(SCALING_INVALID));
    w.scal  = in_req_i.tb_scaling;
    w.rate  = in_req_i.code_rate_x1024;
    w.prb   = in_req_i.prb_count;
    st_d[0] = w;

    // Stage 2: two partial products.
    w       = st_q[0];
    w.a     = 17'(w.re) * 17'(w.prb);
    w.b     = 18'(w.ql) * 18'(w.rate);
    st_d[1] = w;

    // Stage 3: numerator of the information bit count.
    w       = st_q[1];
    w.p     = 35'(w.a) * 35'(w.b);
    st_d[2] = w;

    // Stage 4: branch decision, integer part and the large-branch offset.
    w           = st_q[2];
    dsh         = 4'd10 + 4'(w.scal);
    lim         = 35'(SMALL_LIMIT) << dsh;
    w.use_table = (w.p <= lim);
    w.inum      = 12'(w.p >> dsh);
    w.q         = w.p - (35'(TBS_MIN_BITS) << dsh);
    st_d[3]     = w;

    // Stage 5: leading-one searches and small-branch quantization.
    w       = st_q[3];
    qmsb    = msb_pos35(w.q);
    w.k     = 5'(qmsb - 6'd5);
    imsb    = msb_pos12(w.inum);
    ns      = (w.inum > 12'd512) ? (imsb - 4'd6) : 4'd3;
    qs      = (w.inum >> ns) << ns;
    w.sm    = (qs < 12'(TBS_MIN_BITS)) ? 12'(TBS_MIN_BITS) : qs;
    st_d[4] = w;

    // Stage 6: table lookup and round-half-up quantization for large sizes.
    w       = st_q[4];
    w.sm    = tbs_lookup(w.sm);
    nl      = w.k - 5'd10 - 5'(w.scal);
    rsum    = 36'(w.q) + (36'd1 << (w.k - 5'd1));
    npw     = (rsum >> w.k) << nl;
    npc     = 26'(npw);
    w.np    = (npc < 26'(LARGE_MIN)) ? 26'(LARGE_MIN) : npc;
    st_d[5] = w;

    // Stage 7: code-block count through a reciprocal multiplication.
    w        = st_q[5];
    w.x      = w.np + 26'(TBS_MIN_BITS);
    low      = (w.rate <= 10'(LOW_RATE_X1024));
    kc       = low ? 26'(CB_LOW_RATE) : 26'(CB_HIGH_RATE);
    mc       = low ? 29'(RECIP_LOW) : 29'(RECIP_HIGH);
    w.one_cb = !low && (w.np <= 26'(CB_HIGH_RATE));
    y        = w.x + kc - 26'd1;
    w.prod   = 55'(y) * 55'(mc);
    st_d[6]  = w;

    // Stage 8: take the count.
    w       = st_q[6];
    w.c     = w.one_cb ? 14'd1 : 14'(w.prod >> RECIP_SHIFT);
    st_d[7] = w;

    // Stage 9: divisor 8C and the dividend for a ceiling division.
    w       = st_q[7];
    w.v     = {w.c, 3'b000};
    w.xp    = w.x + 26'(w.v) - 26'd1;
    w.rem   = '0;
    st_d[8] = w;

    // Divider: one dividend bit per stage, most significant dividend bit first.
    for (int j = 0; j < DIV_STEPS; j++) begin
      w   = st_q[DIV_FIRST + j - 1];
      rin = {w.rem, w.xp[DIV_STEPS - 1 - j]};
      if (rin >= 18'(w.v)) begin
        w.rem = 17'(rin - 18'(w.v));
      end else begin
        w.rem = 17'(rin);
      end
      st_d[DIV_FIRST + j] = w;
    end

    // Final stage: xp minus its remainder is the next multiple of 8C.
    w  = st_q[NUM_STAGES - 2];
    tl = w.xp - 26'(w.rem) - 26'(TBS_MIN_BITS);
    if (w.bad) begin
      w.tbs = '0;
    end else if (w.use_table) begin
      w.tbs = 22'(w.sm);
    end else if (tl > 26'(TBS_MAX)) begin
      w.tbs = 22'(TBS_MAX);
    end else begin
      w.tbs = 22'(tl);
    end
    st_d[NUM_STAGES - 1] = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      st_q[0] <= st_d[0];
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (adv[s] && vld_q[s-1]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign out_valid_o           = vld_q[NUM_STAGES-1];
  assign out_rsp_o.tbs_bits    = st_q[NUM_STAGES-1].tbs;
  assign out_rsp_o.bad_scaling = st_q[NUM_STAGES-1].bad;

  // An invalid scaling field always yields a zero size.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_scaling |-> out_rsp_o.tbs_bits == 22'd0)
    else $error("bad scaling response with nonzero size");

  // A valid request never gives a size below the minimum.
  a_min_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.bad_scaling |-> out_rsp_o.tbs_bits >= 22'(TBS_MIN_BITS))
    else $error("transport block size below minimum");

  // Input back-pressure only arises from a stalled, occupied output.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule
